// File: hw/rtl/lamp_fade_breath_pwm_unit_assert.svh
// Assertion macros for the lamp fade and breathing PWM unit.
`ifndef LAMP_FADE_BREATH_PWM_UNIT_ASSERT_SVH
`define LAMP_FADE_BREATH_PWM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lfbp_pkg.sv
// Shared widths, constants and register indexes of the lamp fade and breathing PWM unit.
package lfbp_pkg;

    // Field widths
    localparam int TICK_W     = 8;
    localparam int BRIGHT_W   = 20;
    localparam int COLOR_W    = 17;
    localparam int TRANS_W    = 16;
    localparam int PHASE_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Default behavior constants
    localparam int unsigned FULL_SCALE_DEF    = 1000000;
    localparam int unsigned BREATH_PERIOD_DEF = 10000;

    // Q16 color format
    localparam int Q16_FRAC = 16;
    localparam logic [COLOR_W-1:0] Q16_ONE     = 17'h10000;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 17'd29491;
    localparam logic [TRANS_W-1:0] TRANS_RESET = 16'd1500;

    // Serial divider: numerator bits per job, left aligned in the shift register
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 16;
    localparam int BDIV_BITS = 28;
    localparam int CDIV_BITS = 24;
    localparam int TDIV_BITS = 34;
    localparam int PMOD_BITS = 15;

    // Serial multiplier: multiplicand, multiplier and product widths
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Shared bit counter and signed brightness sum
    localparam int CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int OFF_W = 24;

    // Minimum fade steps
    localparam logic [BDIV_BITS-1:0] BSTEP_MIN = 28'd5000;
    localparam logic [CDIV_BITS-1:0] CSTEP_MIN = 24'd655;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_AMPLITUDE  = 3'd4;

endpackage

// File: hw/rtl/lfbp_if.sv
// Valid/ready channel interfaces for tick requests, duty results and register writes.
interface lfbp_tick_if
    import lfbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] elapsed_ms;

    modport source (output valid, output elapsed_ms, input ready);
    modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface lfbp_duty_if
    import lfbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BRIGHT_W-1:0] cold_pwm;
    logic [BRIGHT_W-1:0] warm_pwm;
    logic [BRIGHT_W-1:0] shown_brightness;

    modport source (output valid, output cold_pwm, output warm_pwm,
                    output shown_brightness, input ready);
    modport sink   (input valid, input cold_pwm, input warm_pwm,
                    input shown_brightness, output ready);
endinterface

interface lfbp_cfg_if
    import lfbp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/lamp_fade_breath_pwm_unit.sv
// Lamp fade and breathing PWM unit: fades brightness and color per tick and emits inverted duties.
//
// Each tick request carries the milliseconds since the last tick and yields one result with the
// inverted cold and warm duties and the shown brightness. All arithmetic runs through one
// bit-serial restoring divider and one bit-serial shift-add multiplier, one bit per cycle. From
// acceptance to the result register a tick passes through brightness step division, color step
// division, fade update, in breath mode triangle product, division by a quarter period and phase
// wrap, then clamping, cold/warm product and result load. A new tick is taken once the previous
// one has reached the result register, even while that result still waits to be taken. Register
// writes are accepted in every cycle and must only be issued while no tick is in flight.
module lamp_fade_breath_pwm_unit
    import lfbp_pkg::*;
#(
    parameter int unsigned FULL_SCALE    = FULL_SCALE_DEF,
    parameter int unsigned BREATH_PERIOD = BREATH_PERIOD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfbp_cfg_if.sink    i_cfg,
    lfbp_tick_if.sink   i_tick,
    lfbp_duty_if.source o_duty
);

`include "lamp_fade_breath_pwm_unit_assert.svh"

    localparam int unsigned QUARTER = (BREATH_PERIOD / 4 < 1) ? 1 : BREATH_PERIOD / 4;

    localparam logic [BRIGHT_W-1:0]     FS_V     = BRIGHT_W'(FULL_SCALE);
    localparam logic [BDIV_BITS-1:0]    FS_BNUM  = BDIV_BITS'(FULL_SCALE);
    localparam logic signed [OFF_W-1:0] FS_OFF   = OFF_W'(FULL_SCALE);
    localparam logic [DIV_DEN_W-1:0]    QUARTER_V = DIV_DEN_W'(QUARTER);
    localparam logic [DIV_DEN_W-1:0]    THREEQ_V  = DIV_DEN_W'(3 * QUARTER);
    localparam logic [DIV_DEN_W-1:0]    PERIOD_V  = DIV_DEN_W'(BREATH_PERIOD);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_BDIV = 10'b00_0000_0010,
        S_CDIV = 10'b00_0000_0100,
        S_MOVE = 10'b00_0000_1000,
        S_TMUL = 10'b00_0001_0000,
        S_TDIV = 10'b00_0010_0000,
        S_PMOD = 10'b00_0100_0000,
        S_SHOW = 10'b00_1000_0000,
        S_CMUL = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    // Control and configuration state
    t_state              r_state;
    t_state              n_state;
    logic [BRIGHT_W-1:0] r_tgt_bright;
    logic [COLOR_W-1:0]  r_tgt_color;
    logic                r_breath;
    logic [TRANS_W-1:0]  r_trans;
    logic [BRIGHT_W-1:0] r_amp;
    logic [BRIGHT_W-1:0] r_cur_bright;
    logic [COLOR_W-1:0]  r_cur_color;
    logic [PHASE_W-1:0]  r_phase;
    logic                r_out_valid;

    // Serial datapath
    logic [TICK_W-1:0]          r_tick;
    logic [DIV_DEN_W-1:0]       r_den;
    logic [DIV_DEN_W-1:0]       r_rem;
    logic [DIV_NUM_W-1:0]       r_dq;
    logic [CNT_W-1:0]           r_cnt;
    logic [PROD_W-1:0]          r_acc;
    logic [MUL_B_W-1:0]         r_mer;
    logic [MUL_A_W-1:0]         r_mcand;
    logic [BDIV_BITS-1:0]       r_bstep;
    logic signed [OFF_W-1:0]    r_offset;
    logic [BRIGHT_W-1:0]        r_cold;
    logic [BRIGHT_W-1:0]        r_warm;
    logic [BRIGHT_W-1:0]        r_shown;

    logic [DIV_DEN_W-1:0]       n_rem;
    logic [DIV_NUM_W-1:0]       n_dq;
    logic [PROD_W-1:0]          n_acc;

    logic                       w_tick_acc;
    logic                       w_last;
    logic                       w_out_load;
    logic [TRANS_W-1:0]         w_t0;
    logic [TRANS_W-1:0]         w_t;
    logic [BDIV_BITS-1:0]       w_bnum;
    logic [DIV_DEN_W:0]         w_trial;
    logic [DIV_DEN_W:0]         w_diff;
    logic                       w_ge;
    logic [MUL_A_W:0]           w_psum;
    logic [BDIV_BITS-1:0]       w_bstep;
    logic [CDIV_BITS-1:0]       w_cstep;
    logic [BRIGHT_W-1:0]        w_new_bright;
    logic [COLOR_W-1:0]         w_new_color;
    logic [DIV_DEN_W-1:0]       w_p16;
    logic [PHASE_W-1:0]         w_tri_m;
    logic [OFF_W-1:0]           w_quot;
    logic [OFF_W-1:0]           w_amp_x;
    logic signed [OFF_W-1:0]    w_offset;
    logic [PMOD_BITS-1:0]       w_pnum;
    logic signed [OFF_W-1:0]    w_sum;
    logic [BRIGHT_W-1:0]        w_b;
    logic [COLOR_W-1:0]         w_c;
    logic [BRIGHT_W-1:0]        w_cold;
    logic                       w_frac;
    logic [BRIGHT_W-1:0]        w_warm;

    // Move cur toward tgt by step, stopping exactly at tgt
    function automatic logic [BRIGHT_W-1:0] f_move(input logic [BRIGHT_W-1:0]  cur,
                                                   input logic [BRIGHT_W-1:0]  tgt,
                                                   input logic [BDIV_BITS-1:0] step);
        logic [BRIGHT_W-1:0] up;
        logic [BRIGHT_W-1:0] dn;
        logic [BRIGHT_W-1:0] res;
        up  = tgt - cur;
        dn  = cur - tgt;
        res = cur;
        if (cur < tgt) begin
            if (BDIV_BITS'(up) <= step) begin
                res = tgt;
            end else begin
                res = cur + step[BRIGHT_W-1:0];
            end
        end else if (cur > tgt) begin
            if (BDIV_BITS'(dn) <= step) begin
                res = tgt;
            end else begin
                res = cur - step[BRIGHT_W-1:0];
            end
        end
        return res;
    endfunction

    // Handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_tick.ready = (r_state == S_IDLE);
    assign w_tick_acc   = i_tick.valid && i_tick.ready;
    assign w_last       = (r_cnt == CNT_W'(1));
    assign w_out_load   = (r_state == S_OUT) && (!r_out_valid || o_duty.ready);

    assign o_duty.valid            = r_out_valid;
    assign o_duty.cold_pwm         = r_cold;
    assign o_duty.warm_pwm         = r_warm;
    assign o_duty.shown_brightness = r_shown;

    // Fade time: transition, else this tick, never zero
    assign w_t0   = (r_trans != '0) ? r_trans : TRANS_W'(i_tick.elapsed_ms);
    assign w_t    = (w_t0 == '0) ? TRANS_W'(1) : w_t0;
    assign w_bnum = FS_BNUM * BDIV_BITS'(i_tick.elapsed_ms);

    // One restoring division step
    assign w_trial = {r_rem, r_dq[DIV_NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
    assign n_dq    = {r_dq[DIV_NUM_W-2:0], w_ge};

    // One shift-add multiplication step
    assign w_psum = {1'b0, r_acc[PROD_W-1:MUL_B_W]} + {1'b0, (r_mer[0] ? r_mcand : '0)};
    assign n_acc  = {w_psum, r_acc[MUL_B_W-1:1]};

    // Fade steps with their floors, applied to both approaches
    assign w_bstep = (r_bstep < BSTEP_MIN) ? BSTEP_MIN : r_bstep;
    assign w_cstep = (r_dq[CDIV_BITS-1:0] < CSTEP_MIN) ? CSTEP_MIN : r_dq[CDIV_BITS-1:0];
    assign w_new_bright = f_move(r_cur_bright, r_tgt_bright, w_bstep);
    assign w_new_color  = COLOR_W'(f_move(BRIGHT_W'(r_cur_color), BRIGHT_W'(r_tgt_color),
                                          BDIV_BITS'(w_cstep)));

    // Triangle: pick the phase offset within the current ramp
    assign w_p16 = DIV_DEN_W'(r_phase);
    always_comb begin
        if (w_p16 < QUARTER_V) begin
            w_tri_m = r_phase;
        end else if (w_p16 < THREEQ_V) begin
            w_tri_m = r_phase - QUARTER_V[PHASE_W-1:0];
        end else begin
            w_tri_m = r_phase - THREEQ_V[PHASE_W-1:0];
        end
    end

    // Triangle: fold the ramp quotient into a signed offset
    assign w_quot  = n_dq[OFF_W-1:0];
    assign w_amp_x = OFF_W'(r_amp);
    always_comb begin
        if (w_p16 < QUARTER_V) begin
            w_offset = signed'(w_quot);
        end else if (w_p16 < THREEQ_V) begin
            w_offset = signed'(w_amp_x - w_quot);
        end else begin
            w_offset = signed'(w_quot - w_amp_x);
        end
    end
    assign w_pnum = PMOD_BITS'(r_phase) + PMOD_BITS'(r_tick);

    // Clamp shown brightness and color share
    assign w_sum = signed'(OFF_W'(r_cur_bright)) + r_offset;
    always_comb begin
        if (w_sum < 0) begin
            w_b = '0;
        end else if (w_sum > FS_OFF) begin
            w_b = FS_V;
        end else begin
            w_b = w_sum[BRIGHT_W-1:0];
        end
    end
    assign w_c = (r_cur_color > Q16_ONE) ? Q16_ONE : r_cur_color;

    // Split into cold and warm levels; warm subtracts the rounded-up cold product from brightness
    assign w_cold = r_acc[Q16_FRAC +: BRIGHT_W];
    assign w_frac = |r_acc[Q16_FRAC-1:0];
    assign w_warm = r_mcand - w_cold - BRIGHT_W'(w_frac);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_tick_acc) n_state = S_BDIV;
            S_BDIV: if (w_last) n_state = S_CDIV;
            S_CDIV: if (w_last) n_state = S_MOVE;
            S_MOVE: n_state = r_breath ? S_TMUL : S_SHOW;
            S_TMUL: if (w_last) n_state = S_TDIV;
            S_TDIV: if (w_last) n_state = S_PMOD;
            S_PMOD: if (w_last) n_state = S_SHOW;
            S_SHOW: n_state = S_CMUL;
            S_CMUL: if (w_last) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control, configuration and fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tgt_bright <= '0;
            r_tgt_color  <= COLOR_RESET;
            r_breath     <= 1'b0;
            r_trans      <= TRANS_RESET;
            r_amp        <= '0;
            r_cur_bright <= '0;
            r_cur_color  <= COLOR_RESET;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TARGET_BRIGHTNESS: r_tgt_bright <= i_cfg.data[BRIGHT_W-1:0];
                    REG_TARGET_COLOR:      r_tgt_color  <= i_cfg.data[COLOR_W-1:0];
                    REG_BREATH_MODE:       r_breath     <= i_cfg.data[0];
                    REG_TRANSITION_MS:     r_trans      <= i_cfg.data[TRANS_W-1:0];
                    REG_BREATH_AMPLITUDE:  r_amp        <= i_cfg.data[BRIGHT_W-1:0];
                    default: ;
                endcase
            end

            // Advance the fade; hold phase at zero when static
            if (r_state == S_MOVE) begin
                r_cur_bright <= w_new_bright;
                r_cur_color  <= w_new_color;
                if (!r_breath) begin
                    r_phase <= '0;
                end
            end

            // Wrap the breathing phase
            if (r_state == S_PMOD && w_last) begin
                r_phase <= n_rem[PHASE_W-1:0];
            end

            // Result register handshake
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_duty.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Serial divider, multiplier and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_tick_acc) begin
                    r_tick <= i_tick.elapsed_ms;
                    r_den  <= w_t;
                    r_rem  <= '0;
                    r_dq   <= DIV_NUM_W'(w_bnum) << (DIV_NUM_W - BDIV_BITS);
                    r_cnt  <= CNT_W'(BDIV_BITS);
                end
            end
            S_BDIV: begin
                if (w_last) begin
                    r_bstep <= n_dq[BDIV_BITS-1:0];
                    r_rem   <= '0;
                    r_dq    <= DIV_NUM_W'({r_tick, {Q16_FRAC{1'b0}}}) << (DIV_NUM_W - CDIV_BITS);
                    r_cnt   <= CNT_W'(CDIV_BITS);
                end else begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_CDIV: begin
                r_dq  <= n_dq;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_MOVE: begin
                if (r_breath) begin
                    r_mcand <= r_amp;
                    r_mer   <= MUL_B_W'(w_tri_m);
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(MUL_B_W);
                end else begin
                    r_offset <= '0;
                end
            end
            S_TMUL: begin
                r_acc <= n_acc;
                r_mer <= r_mer >> 1;
                if (w_last) begin
                    r_dq  <= n_acc[DIV_NUM_W-1:0];
                    r_den <= QUARTER_V;
                    r_rem <= '0;
                    r_cnt <= CNT_W'(TDIV_BITS);
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_TDIV: begin
                if (w_last) begin
                    r_offset <= w_offset;
                    r_dq     <= DIV_NUM_W'(w_pnum) << (DIV_NUM_W - PMOD_BITS);
                    r_den    <= PERIOD_V;
                    r_rem    <= '0;
                    r_cnt    <= CNT_W'(PMOD_BITS);
                end else begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_PMOD: begin
                r_dq  <= n_dq;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_SHOW: begin
                r_mcand <= w_b;
                r_mer   <= w_c;
                r_acc   <= '0;
                r_cnt   <= CNT_W'(MUL_B_W);
            end
            S_CMUL: begin
                r_acc <= n_acc;
                r_mer <= r_mer >> 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_cold  <= FS_V - w_cold;
                    r_warm  <= FS_V - w_warm;
                    r_shown <= r_mcand;
                end
            end
            default: ;
        endcase
    end

    // Checks on sequencing and ranges
    `LFBP_ASSERT_NXT(a_accept_starts_div, w_tick_acc, r_state == S_BDIV, "tick did not start")
    `LFBP_ASSERT_IMP(a_phase_in_range, 1'b1, r_phase < PHASE_W'(BREATH_PERIOD), "phase out of range")
    `LFBP_ASSERT_IMP(a_shown_clamped, r_out_valid, r_shown <= FS_V, "shown above full scale")
    `LFBP_ASSERT_NXT(a_no_overwrite, r_out_valid && !o_duty.ready, r_out_valid, "result dropped")

endmodule
